FILE: src/prbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbt_pkg
// Shared types, constants and the address-step table for the paged register
// bank target.
// ----------------------------------------------------------------------------
package prbt_pkg;

    localparam int STORE_SIZE  = 256;
    localparam int ADDR_W      = 8;
    localparam int DATA_W      = 8;
    localparam int BANK_BYTES  = 128;
    localparam int READ_WINDOW = 128;
    localparam int RD_CNT_W    = $clog2(READ_WINDOW + 1);
    localparam int WR_CNT_W    = 2;

    localparam logic [RD_CNT_W-1:0] RD_WIN_LIMIT = RD_CNT_W'(READ_WINDOW);
    localparam logic [WR_CNT_W-1:0] WR_CNT_MAX   = WR_CNT_W'(2);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef logic [STORE_SIZE-1:0][ADDR_W-1:0] next_table_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } mem_req_t;

    function automatic next_table_t build_next_table();
        next_table_t t;
        int          base;
        int          off;
        for (int i = 0; i < STORE_SIZE; i++)
        begin
            base = (i / BANK_BYTES) * BANK_BYTES;
            off  = (i % BANK_BYTES) + 1;
            if (off >= BANK_BYTES || base + off >= STORE_SIZE)
            begin
                off = 0;
            end
            t[i] = ADDR_W'(base + off);
        end
        return t;
    endfunction

    localparam next_table_t NEXT_ADDR = build_next_table();

endpackage

FILE: src/prbt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prbt_mem
// Byte store with registered synchronous read; per-entry valid bits make
// entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module prbt_mem
    import prbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0]     store_mem_reg [STORE_SIZE];
    logic [STORE_SIZE-1:0] vld_reg;
    logic [STORE_SIZE-1:0] vld_next;
    logic [DATA_W-1:0]     q_reg;
    logic                  q_vld_reg;
    logic                  q_vld_next;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            store_mem_reg[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            q_reg <= store_mem_reg[req.addr];
        end
    end

    always_comb
    begin
        vld_next   = vld_reg;
        q_vld_next = q_vld_reg;
        if (req.wr_en)
        begin
            vld_next[req.addr] = 1'b1;
        end
        if (req.rd_en)
        begin
            q_vld_next = vld_reg[req.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            q_vld_reg <= q_vld_next;
        end
    end

    assign rdata = q_vld_reg ? q_reg : '0;

endmodule

FILE: src/paged_register_bank_target.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_register_bank_target
// Target-side register map: 256 bytes in banks with an auto-incrementing
// pointer that wraps inside its bank.
// ----------------------------------------------------------------------------
// Usage:
// - request channel (req_valid / req_stall) carries one bus event per item:
//   kind and byte_in. the response channel (rsp_valid / rsp_stall) returns
//   exactly one item per request: read_data, underrun and pointer.
// - an item is taken at its accepting edge; the byte store is read at the
//   accepting edge and the response is registered on the next edge, so
//   rsp_valid rises in the cycle after the accepting edge.
// - at most one item is in flight: the single-port byte store read and
//   its response cycle are owned by one item at a time, so a new item waits.
// - req_stall is high during the response cycle and while a finished
//   response waits on rsp_stall; the waiting response holds still.
// - reset clears pointer, counters and the rsp_valid flag; valid bits in
//   the store make every byte read as zero until written, so no clearing
//   pass is needed and items are taken right after reset.
// ----------------------------------------------------------------------------
module paged_register_bank_target
    import prbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        kind,
    input  logic [DATA_W-1:0] byte_in,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              underrun,
    output logic [ADDR_W-1:0] pointer
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   ptr_reg;
    logic [ADDR_W-1:0]   ptr_next;
    logic [WR_CNT_W-1:0] wcnt_reg;
    logic [WR_CNT_W-1:0] wcnt_next;
    logic [RD_CNT_W-1:0] rcnt_reg;
    logic [RD_CNT_W-1:0] rcnt_next;
    logic                rd_ok_reg;
    logic                rd_ok_next;
    logic                under_reg;
    logic                under_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    logic [DATA_W-1:0]   read_data_reg;
    logic [DATA_W-1:0]   read_data_next;
    logic                underrun_reg;
    logic                underrun_next;
    logic [ADDR_W-1:0]   pointer_reg;
    logic [ADDR_W-1:0]   pointer_next;
    logic                accept;
    mem_req_t            mreq;
    logic [DATA_W-1:0]   mem_rdata;

    assign req_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        wcnt_next      = wcnt_reg;
        rcnt_next      = rcnt_reg;
        rd_ok_next     = rd_ok_reg;
        under_next     = under_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        read_data_next = read_data_reg;
        underrun_next  = underrun_reg;
        pointer_next   = pointer_reg;
        mreq           = '{wr_en: 1'b0, rd_en: 1'b0, addr: ptr_reg, wdata: byte_in};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RESP;
                    rd_ok_next = 1'b0;
                    under_next = 1'b0;
                    case (kind_t'(kind))
                        KIND_WRITE:
                        begin
                            rcnt_next = '0;
                            if (wcnt_reg == '0)
                            begin
                                ptr_next = byte_in;
                            end
                            else
                            begin
                                mreq.wr_en = 1'b1;
                                ptr_next   = NEXT_ADDR[ptr_reg];
                            end
                            if (wcnt_reg < WR_CNT_MAX)
                            begin
                                wcnt_next = wcnt_reg + 1'b1;
                            end
                        end
                        KIND_READ:
                        begin
                            wcnt_next = '0;
                            if (rcnt_reg < RD_WIN_LIMIT)
                            begin
                                mreq.rd_en = 1'b1;
                                rd_ok_next = 1'b1;
                                ptr_next   = NEXT_ADDR[ptr_reg];
                                rcnt_next  = rcnt_reg + 1'b1;
                            end
                            else
                            begin
                                under_next = 1'b1;
                            end
                        end
                        KIND_END:
                        begin
                            wcnt_next = '0;
                            rcnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                state_next     = ST_IDLE;
                rsp_valid_next = 1'b1;
                read_data_next = rd_ok_reg ? mem_rdata : '0;
                underrun_next  = under_reg;
                pointer_next   = ptr_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            wcnt_reg      <= '0;
            rcnt_reg      <= '0;
            rd_ok_reg     <= 1'b0;
            under_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            wcnt_reg      <= wcnt_next;
            rcnt_reg      <= rcnt_next;
            rd_ok_reg     <= rd_ok_next;
            under_reg     <= under_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        underrun_reg  <= underrun_next;
        pointer_reg   <= pointer_next;
    end

    prbt_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (mem_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign read_data = read_data_reg;
    assign underrun  = underrun_reg;
    assign pointer   = pointer_reg;

`ifndef SYNTHESIS
    a_accept_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RESP))
        else $error("accepted item did not enter response cycle");

    a_resp_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) |=> rsp_valid_reg)
        else $error("response cycle did not present an item");

    a_underrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && underrun_reg) |-> (read_data_reg == '0))
        else $error("underrun item carries nonzero data");

    a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= RD_WIN_LIMIT)
        else $error("read count past window");

    a_no_read_and_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(mreq.wr_en && mreq.rd_en))
        else $error("store read and written by one item");
`endif

endmodule
